@@ src/primality_test_64bit_assert.svh @@
// Assertion macros for the primality tester checker
`ifndef PRIMALITY_TEST_64BIT_ASSERT_SVH
`define PRIMALITY_TEST_64BIT_ASSERT_SVH

// same-cycle implication, clocked on clk, held off in reset
`define PT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// next-cycle implication
`define PT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

@@ src/pt64_pkg.sv @@
// ----------------------------------------------------------------------------
// pt64_pkg
// Shared constants and types of the 64-bit primality tester.
// ----------------------------------------------------------------------------
package pt64_pkg;

	localparam int NUM_TRIAL = 4;
	localparam int NUM_BASES = 7;

	localparam logic [3:0] TRIAL_PRIMES [NUM_TRIAL] = '{4'd2, 4'd3, 4'd5, 4'd7};

	localparam logic [31:0] SPRP_BASES [NUM_BASES] = '{
		32'd2, 32'd325, 32'd9375, 32'd28178,
		32'd450775, 32'd9780504, 32'd1795265022
	};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_TRIAL_GO,
		ST_TRIAL_WAIT,
		ST_FACTOR,
		ST_BASE_GO,
		ST_BASE_WAIT,
		ST_POW_CHK,
		ST_POW_MUL_WAIT,
		ST_POW_SQR_GO,
		ST_POW_SQR_WAIT,
		ST_X_CHK,
		ST_SQ_CHK,
		ST_SQ_WAIT,
		ST_PASS,
		ST_DONE
	} state_t;

endpackage

@@ src/pt64_if.sv @@
// ----------------------------------------------------------------------------
// pt64_if
// Valid/ready channels: candidate in, verdict out.
// ----------------------------------------------------------------------------
interface pt64_cand_if;
	logic        valid;
	logic        ready;
	logic [63:0] candidate;

	modport source (output valid, output candidate, input ready);
	modport sink   (input valid, input candidate, output ready);
endinterface

interface pt64_res_if;
	logic valid;
	logic ready;
	logic prime_flag;

	modport source (output valid, output prime_flag, input ready);
	modport sink   (input valid, input prime_flag, output ready);
endinterface

@@ src/pt64_modmul.sv @@
// ----------------------------------------------------------------------------
// pt64_modmul
// Bit-serial modular multiplier: x * y mod m, one bit of y per step.
// ----------------------------------------------------------------------------
module pt64_modmul #(
	parameter int W  = 64,
	parameter int YW = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [W-1:0]  x,
	input  logic [YW-1:0] y,
	input  logic [W-1:0]  m,
	output logic          done,
	output logic [W-1:0]  prod
);
	localparam int CW = $clog2(YW + 1);

	logic [W-1:0]  acc_q;
	logic [W-1:0]  x_q;
	logic [W-1:0]  m_q;
	logic [YW-1:0] y_q;
	logic [CW-1:0] cnt_q;
	logic          ph_q;
	logic          busy_q;
	logic          done_q;
	logic [W-1:0]  sum;

	// (a + b) mod m for a, b < m
	function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, input logic [W-1:0] b,
			input logic [W-1:0] md);
		logic [W:0]   s;
		logic [W+1:0] t;
		s = {1'b0, a} + {1'b0, b};
		t = {1'b0, s} - {2'b00, md};
		return t[W+1] ? s[W-1:0] : t[W-1:0];
	endfunction

	// phase 0 doubles, phase 1 adds x when the current bit of y is set
	assign sum = ph_q ? add_mod(acc_q, x_q, m_q) : add_mod(acc_q, acc_q, m_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ph_q   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				ph_q   <= 1'b0;
				cnt_q  <= CW'(YW);
			end else if (busy_q) begin
				if (!ph_q && y_q[YW-1]) begin
					ph_q <= 1'b1;
				end else begin
					ph_q  <= 1'b0;
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
			m_q   <= m;
		end else if (busy_q) begin
			acc_q <= sum;
			if (ph_q || !y_q[YW-1])
				y_q <= {y_q[YW-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule

@@ src/primality_test_64bit.sv @@
// Work: a candidate below 2 skips all multiplies; otherwise trial division takes up to 4 modular
// multiplies (multiplier operand y is YW = max(WIDTH, 32) bits wide), and each of 7 bases up to
// about 2*WIDTH multiplies.
// Throughput: one item at a time; set by the single shared bit-serial multiplier.
// Reset: arst_n clears the sequencer and the output valid; payload regs are not reset.
// ----------------------------------------------------------------------------
// primality_test_64bit
// Deterministic Miller-Rabin test: trial division by 2, 3, 5, 7, then strong
// probable-prime tests to seven fixed bases, all on one serial multiplier.
// ----------------------------------------------------------------------------
module primality_test_64bit import pt64_pkg::*; #(
	parameter int WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	pt64_cand_if.sink   cand,
	pt64_res_if.source  res
);
	localparam int YW = (WIDTH > 32) ? WIDTH : 32;
	localparam int SW = $clog2(WIDTH);

	state_t state_q, state_d;

	logic [WIDTH-1:0] n_q;      // candidate under test
	logic [WIDTH-1:0] nm1_q;    // n - 1
	logic [WIDTH-1:0] d_q;      // odd part of n - 1
	logic [SW-1:0]    s_q;      // power of two in n - 1
	logic [SW-1:0]    r_q;      // squaring round
	logic [WIDTH-1:0] e_q;      // remaining exponent
	logic [WIDTH-1:0] acc_q;    // running power, later x
	logic [WIDTH-1:0] b_q;      // repeated square of the base
	logic [1:0]       tidx_q;
	logic [2:0]       bidx_q;
	logic             verdict_q;
	logic             out_valid_q;
	logic             out_bit_q;

	// multiplier hookup
	logic             mm_start;
	logic [WIDTH-1:0] mm_x;
	logic [YW-1:0]    mm_y;
	logic [WIDTH-1:0] mm_m;
	logic             mm_done;
	logic [WIDTH-1:0] mm_prod;

	logic [WIDTH-1:0] prime_w;
	logic             out_free;

	assign prime_w  = WIDTH'(TRIAL_PRIMES[tidx_q]);
	assign out_free = !out_valid_q || res.ready;

	pt64_modmul #(.W(WIDTH), .YW(YW)) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mm_start),
		.x     (mm_x),
		.y     (mm_y),
		.m     (mm_m),
		.done  (mm_done),
		.prod  (mm_prod)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:         if (cand.valid) state_d = ST_CHECK;
			ST_CHECK:        state_d = (n_q < WIDTH'(2)) ? ST_DONE : ST_TRIAL_GO;
			ST_TRIAL_GO:     state_d = ST_TRIAL_WAIT;
			ST_TRIAL_WAIT: begin
				if (mm_done) begin
					if (mm_prod == '0)
						state_d = ST_DONE;
					else if (tidx_q == 2'(NUM_TRIAL - 1))
						state_d = ST_FACTOR;
					else
						state_d = ST_TRIAL_GO;
				end
			end
			ST_FACTOR:       if (d_q[0]) state_d = ST_BASE_GO;
			ST_BASE_GO:      state_d = ST_BASE_WAIT;
			ST_BASE_WAIT: begin
				// base that vanishes mod n passes outright
				if (mm_done) state_d = (mm_prod == '0) ? ST_PASS : ST_POW_CHK;
			end
			ST_POW_CHK: begin
				if (e_q == '0)
					state_d = ST_X_CHK;
				else if (e_q[0])
					state_d = ST_POW_MUL_WAIT;
				else
					state_d = ST_POW_SQR_WAIT;
			end
			ST_POW_MUL_WAIT: if (mm_done) state_d = ST_POW_SQR_GO;
			ST_POW_SQR_GO:   state_d = ST_POW_SQR_WAIT;
			ST_POW_SQR_WAIT: if (mm_done) state_d = ST_POW_CHK;
			ST_X_CHK: begin
				state_d = (acc_q == WIDTH'(1) || acc_q == nm1_q) ? ST_PASS : ST_SQ_CHK;
			end
			ST_SQ_CHK:       state_d = (r_q < s_q) ? ST_SQ_WAIT : ST_DONE;
			ST_SQ_WAIT:      if (mm_done) state_d = (mm_prod == nm1_q) ? ST_PASS : ST_SQ_CHK;
			ST_PASS:         state_d = (bidx_q == 3'(NUM_BASES - 1)) ? ST_DONE : ST_BASE_GO;
			ST_DONE:         if (out_free) state_d = ST_IDLE;
			default:         state_d = ST_IDLE;
		endcase
	end

	// multiplier requests
	always_comb begin
		mm_start = 1'b0;
		mm_x     = acc_q;
		mm_y     = YW'(b_q);
		mm_m     = n_q;
		case (state_q)
			ST_TRIAL_GO: begin
				mm_start = 1'b1;
				mm_x     = WIDTH'(1);
				mm_y     = YW'(n_q);
				mm_m     = prime_w;
			end
			ST_BASE_GO: begin
				mm_start = 1'b1;
				mm_x     = WIDTH'(1);
				mm_y     = YW'(SPRP_BASES[bidx_q]);
			end
			ST_POW_CHK: begin
				mm_start = (e_q != '0);
				if (!e_q[0])
					mm_x = b_q;
			end
			ST_POW_SQR_GO: begin
				mm_start = 1'b1;
				mm_x     = b_q;
			end
			ST_SQ_CHK: begin
				mm_start = (r_q < s_q);
				mm_y     = YW'(acc_q);
			end
			default: begin
				mm_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (res.ready)
				out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				n_q       <= cand.candidate[WIDTH-1:0];
				verdict_q <= 1'b0;
			end
			ST_CHECK: tidx_q <= '0;
			ST_TRIAL_WAIT: begin
				if (mm_done) begin
					verdict_q <= (n_q == prime_w);
					tidx_q    <= tidx_q + 2'd1;
					nm1_q     <= n_q - WIDTH'(1);
					d_q       <= n_q - WIDTH'(1);
					s_q       <= '0;
					bidx_q    <= '0;
				end
			end
			ST_FACTOR: begin
				if (!d_q[0]) begin
					d_q <= d_q >> 1;
					s_q <= s_q + SW'(1);
				end
			end
			ST_BASE_WAIT: begin
				if (mm_done) begin
					b_q   <= mm_prod;
					acc_q <= WIDTH'(1);
					e_q   <= d_q;
				end
			end
			ST_POW_MUL_WAIT: if (mm_done) acc_q <= mm_prod;
			ST_POW_SQR_WAIT: begin
				if (mm_done) begin
					b_q <= mm_prod;
					e_q <= e_q >> 1;
				end
			end
			ST_X_CHK: r_q <= SW'(1);
			ST_SQ_CHK: if (!(r_q < s_q)) verdict_q <= 1'b0;
			ST_SQ_WAIT: begin
				if (mm_done) begin
					acc_q <= mm_prod;
					r_q   <= r_q + SW'(1);
				end
			end
			ST_PASS: begin
				bidx_q    <= bidx_q + 3'd1;
				verdict_q <= 1'b1;
			end
			ST_DONE: if (out_free) out_bit_q <= verdict_q;
			default: ;
		endcase
	end

	assign cand.ready     = (state_q == ST_IDLE);
	assign res.valid      = out_valid_q;
	assign res.prime_flag = out_bit_q;
endmodule

@@ src/pt64_checker.sv @@
// ----------------------------------------------------------------------------
// pt64_checker
// Port-level checks on the primality tester, bound to the top level.
// ----------------------------------------------------------------------------
`include "primality_test_64bit_assert.svh"

module pt64_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_bit
);
	`PT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`PT_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_bit))
	`PT_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready && !$rose(out_valid))
	`PT_ASSERT_NOW(a_result_frees_input, $rose(out_valid), in_ready)
endmodule

bind primality_test_64bit pt64_checker u_pt64_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (cand.valid),
	.in_ready (cand.ready),
	.out_valid(res.valid),
	.out_ready(res.ready),
	.out_bit  (res.prime_flag)
);
